FILE: rtl/core/glmd_pkg.sv
// Shared types, constants and the helper function of the grid local minimum detector.
package glmd_pkg;

    localparam int PIX_W      = 4;
    localparam int ROW_W      = 7;
    localparam int COL_W      = 7;
    localparam int RISK_W     = 19;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int RESET_DIM      = 128;

    localparam logic [RISK_W-1:0] RISK_MAX = {RISK_W{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    // Result kinds.
    localparam logic KIND_LOW  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Result slots of one pixel, in the order the results leave.
    localparam int SLOT_UP    = 0;
    localparam int SLOT_LEFT  = 1;
    localparam int SLOT_FINAL = 2;
    localparam int SLOT_DONE  = 3;
    localparam int NUM_SLOTS  = 4;
    localparam int NUM_CANDS  = 3;

    // Result queue.
    localparam int RQ_DEPTH = 8;
    localparam int RQ_PW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    typedef logic [PIX_W-1:0]      pix_t;
    typedef logic [ROW_W-1:0]      row_t;
    typedef logic [COL_W-1:0]      col_t;
    typedef logic [RISK_W-1:0]     risk_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // A candidate low point found when a pixel arrives.
    typedef struct packed {
        row_t row;
        col_t col;
        pix_t h;
    } cand_t;

    // One result word as it waits in the result queue.
    typedef struct packed {
        logic  kind;
        row_t  row;
        col_t  col;
        pix_t  cell_height;
        risk_t risk_total;
        logic  last_of_run;
    } res_word_t;

    // Adds height plus one to the running total and clips at the maximum.
    function automatic risk_t risk_add(input risk_t total, input pix_t h);
        logic [RISK_W:0] sum;
        sum = {1'b0, total} + (RISK_W + 1)'(h) + (RISK_W + 1)'(1);
        if (sum > {1'b0, RISK_MAX})
        begin
            return RISK_MAX;
        end
        return sum[RISK_W-1:0];
    endfunction

endpackage

FILE: rtl/core/glmd_ifs.sv
// Handshake interfaces of the pixel, result and configuration channels.
interface glmd_pixel_if import glmd_pkg::*; ();
    logic valid;
    logic ready;
    pix_t height;

    modport source (output valid, output height, input ready);
    modport sink (input valid, input height, output ready);
endinterface

interface glmd_result_if import glmd_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  kind;
    row_t  row;
    col_t  col;
    pix_t  cell_height;
    risk_t risk_total;
    logic  last_of_run;

    modport source (output valid, output kind, output row, output col, output cell_height,
                    output risk_total, output last_of_run, input ready);
    modport sink (input valid, input kind, input row, input col, input cell_height,
                  input risk_total, input last_of_run, output ready);
endinterface

interface glmd_cfg_if import glmd_pkg::*; ();
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/glmd_cell.sv
// One stage of a pixel line: loads a new pixel when it is the entry point, else takes its neighbor's.
module glmd_cell import glmd_pkg::*;
(
    input  logic clk,
    input  logic shift,
    input  logic load,
    input  pix_t pix_in,
    input  pix_t prev_in,
    output pix_t q
);

    pix_t q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= load ? pix_in : prev_in;
        end
    end

    assign q = q_reg;

endmodule

FILE: rtl/core/glmd_line_chain.sv
// Chain of pixel cells with a movable entry point, forming a delay line of programmable length.
module glmd_line_chain import glmd_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int IW    = $clog2(DEF_MAX_WIDTH + 2)
)
(
    input  logic          clk,
    input  logic          shift,
    input  logic [IW-1:0] entry,
    input  pix_t          pix_in,
    output pix_t          taps [DEPTH]
);

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_stage
        pix_t prev;

        if (k == 0)
        begin : g_first
            assign prev = pix_in;
        end
        else
        begin : g_next
            assign prev = taps[k-1];
        end

        glmd_cell u_stage (
            .clk     (clk),
            .shift   (shift),
            .load    (entry == IW'(k)),
            .pix_in  (pix_in),
            .prev_in (prev),
            .q       (taps[k])
        );
    end

endmodule

FILE: rtl/core/grid_local_minimum_detector.sv
// Top level of the grid local minimum detector: line delay chains, decision stage and result queue.
//
//   Channel   Modport  Words carried                                       Accepted when
//   pixels    sink     height of the next pixel, row-major order            valid && ready
//   results   source   kind, row, col, cell_height, risk_total, last_of_run  valid && ready
//   cfg       sink     index (0 frame_width, 1 frame_height), data          valid && ready
//
// One pixel is accepted per clock while pixels.ready is high. Its result words wait in the
// staging register until the queue has room for all of them, then enter the queue together.
// Words leave at one per clock while results.ready is high, through an eight word queue, so
// the output port sets the pace whenever pixels cause more than one word each.
// Reset clears the counters, the running total, the staging register and the queue; the line
// cells hold garbage until the frame writes them, and there is no clearing pass.
// pixels.ready drops only while the staged pixel's words do not fit into the queue.
// cfg.ready is always high; any write to a known register restarts the frame.
module grid_local_minimum_detector import glmd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic clk,
    input  logic rst_n,
    glmd_pixel_if.sink    pixels,
    glmd_result_if.source results,
    glmd_cfg_if.sink      cfg
);

    // Column and row counter widths.
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // The first line chain delivers the pixels w-1, w and w+1 steps back on its last three
    // cells; the second one is fed from the w tap and delivers the pixel 2w steps back.
    localparam int NA = MAX_WIDTH + 2;
    localparam int NB = MAX_WIDTH;
    localparam int EW = $clog2(MAX_WIDTH + 2);

    localparam int W_RST = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
    localparam int H_RST = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

    // ------------------------------------------------------------------
    // Configuration. The clamped width is kept as the last column index
    // and as the entry points of both chains.
    // ------------------------------------------------------------------
    logic [XW-1:0] w_last_reg,  w_last_next;
    logic [YW-1:0] h_last_reg,  h_last_next;
    logic [EW-1:0] entry_a_reg, entry_a_next;
    logic [EW-1:0] entry_b_reg, entry_b_next;
    logic          cfg_we;
    logic          cfg_restart;
    int            w_eff;
    int            h_eff;

    assign cfg.ready   = 1'b1;
    assign cfg_we      = cfg.valid && cfg.ready;
    assign cfg_restart = cfg_we && (cfg.index == REG_FRAME_WIDTH ||
                                    cfg.index == REG_FRAME_HEIGHT);

    always_comb
    begin
        w_eff = int'(cfg.data);
        if (w_eff == 0)
        begin
            w_eff = 1;
        end
        else if (w_eff > MAX_WIDTH)
        begin
            w_eff = MAX_WIDTH;
        end

        h_eff = int'(cfg.data);
        if (h_eff == 0)
        begin
            h_eff = 1;
        end
        else if (h_eff > MAX_HEIGHT)
        begin
            h_eff = MAX_HEIGHT;
        end

        w_last_next  = w_last_reg;
        h_last_next  = h_last_reg;
        entry_a_next = entry_a_reg;
        entry_b_next = entry_b_reg;
        if (cfg_we)
        begin
            unique case (cfg.index)
                REG_FRAME_WIDTH:
                begin
                    w_last_next  = XW'(w_eff - 1);
                    entry_a_next = EW'(MAX_WIDTH + 1 - w_eff);
                    entry_b_next = EW'(MAX_WIDTH - w_eff);
                end
                REG_FRAME_HEIGHT:
                begin
                    h_last_next = YW'(h_eff - 1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg  <= XW'(W_RST - 1);
            h_last_reg  <= YW'(H_RST - 1);
            entry_a_reg <= EW'(MAX_WIDTH + 1 - W_RST);
            entry_b_reg <= EW'(MAX_WIDTH - W_RST);
        end
        else
        begin
            w_last_reg  <= w_last_next;
            h_last_reg  <= h_last_next;
            entry_a_reg <= entry_a_next;
            entry_b_reg <= entry_b_next;
        end
    end

    // ------------------------------------------------------------------
    // Line chains and the two most recent pixels of the current row.
    // ------------------------------------------------------------------
    logic accept;
    pix_t line_a [NA];
    pix_t line_b [NB];
    pix_t pix;

    assign pix = pixels.height;

    glmd_line_chain #(.DEPTH(NA), .IW(EW)) u_line_a (
        .clk    (clk),
        .shift  (accept),
        .entry  (entry_a_reg),
        .pix_in (pix),
        .taps   (line_a)
    );

    glmd_line_chain #(.DEPTH(NB), .IW(EW)) u_line_b (
        .clk    (clk),
        .shift  (accept),
        .entry  (entry_b_reg),
        .pix_in (line_a[NA-2]),
        .taps   (line_b)
    );

    pix_t recent0_reg, recent1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent0_reg <= '0;
            recent1_reg <= '0;
        end
        else if (accept)
        begin
            recent1_reg <= recent0_reg;
            recent0_reg <= pix;
        end
    end

    // ------------------------------------------------------------------
    // Decision logic. With w the row width, the taps hold:
    //   same column one row up (tap_w), the cell right of it (tap_wm1),
    //   the cell left of it (tap_wp1) and the cell two rows up (tap_2w).
    // ------------------------------------------------------------------
    logic [XW-1:0] col_reg;
    logic [YW-1:0] row_reg;
    pix_t          tap_wm1, tap_w, tap_wp1, tap_2w;
    logic          last_row, last_col;
    logic          row_nz, col_nz;
    logic [NUM_SLOTS-1:0] slot_found;
    cand_t         cand [NUM_CANDS];

    assign tap_wp1  = line_a[NA-1];
    assign tap_w    = line_a[NA-2];
    assign tap_wm1  = line_a[NA-3];
    assign tap_2w   = line_b[NB-1];
    assign last_row = (row_reg == h_last_reg);
    assign last_col = (col_reg == w_last_reg);
    assign row_nz   = (row_reg != '0);
    assign col_nz   = (col_reg != '0);

    always_comb
    begin
        // The cell one row up is decided by its lower neighbor, the new pixel.
        slot_found[SLOT_UP] = row_nz && (pix > tap_w);
        if (row_reg > YW'(1) && tap_2w <= tap_w)
        begin
            slot_found[SLOT_UP] = 1'b0;
        end
        if (col_nz && tap_wp1 <= tap_w)
        begin
            slot_found[SLOT_UP] = 1'b0;
        end
        if (!last_col && tap_wm1 <= tap_w)
        begin
            slot_found[SLOT_UP] = 1'b0;
        end

        // In the bottom row the cell to the left is decided by its right neighbor.
        slot_found[SLOT_LEFT] = last_row && col_nz && (pix > recent0_reg);
        if (row_nz && tap_wp1 <= recent0_reg)
        begin
            slot_found[SLOT_LEFT] = 1'b0;
        end
        if (col_reg > XW'(1) && recent1_reg <= recent0_reg)
        begin
            slot_found[SLOT_LEFT] = 1'b0;
        end

        // The final pixel of the frame has only its upper and left neighbors.
        slot_found[SLOT_FINAL] = last_row && last_col;
        if (row_nz && tap_w <= pix)
        begin
            slot_found[SLOT_FINAL] = 1'b0;
        end
        if (col_nz && recent0_reg <= pix)
        begin
            slot_found[SLOT_FINAL] = 1'b0;
        end

        slot_found[SLOT_DONE] = last_row && last_col;

        cand[SLOT_UP].row    = ROW_W'(row_reg - 1'b1);
        cand[SLOT_UP].col    = COL_W'(col_reg);
        cand[SLOT_UP].h      = tap_w;
        cand[SLOT_LEFT].row  = ROW_W'(row_reg);
        cand[SLOT_LEFT].col  = COL_W'(col_reg - 1'b1);
        cand[SLOT_LEFT].h    = recent0_reg;
        cand[SLOT_FINAL].row = ROW_W'(row_reg);
        cand[SLOT_FINAL].col = COL_W'(col_reg);
        cand[SLOT_FINAL].h   = pix;
    end

    // Position of the next pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_restart)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Staging register: the found results of one pixel wait here until the
    // queue has room for all of them.
    // ------------------------------------------------------------------
    logic                 p1_valid_reg;
    logic [NUM_SLOTS-1:0] p1_slot_reg;
    cand_t                p1_cand_reg [NUM_CANDS];
    logic [RQ_CW-1:0]     p1_count;
    logic [RQ_CW-1:0]     rq_count_reg, rq_count_next;
    logic                 move;
    logic                 in_ready;

    assign p1_count      = RQ_CW'($countones(p1_slot_reg));
    assign move          = p1_valid_reg && ((RQ_CW'(RQ_DEPTH) - rq_count_reg) >= p1_count);
    assign in_ready      = !p1_valid_reg || move;
    assign pixels.ready  = in_ready;
    assign accept        = pixels.valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_slot_reg  <= '0;
        end
        else if (accept)
        begin
            p1_valid_reg <= 1'b1;
            p1_slot_reg  <= slot_found;
        end
        else if (move)
        begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_cand_reg <= cand;
        end
    end

    // ------------------------------------------------------------------
    // Running total and result words of the staged pixel.
    // ------------------------------------------------------------------
    risk_t     risk_reg;
    risk_t     run_total [NUM_SLOTS];
    res_word_t word [NUM_SLOTS];
    logic [1:0] slot_pos [NUM_SLOTS];
    logic      later_found;

    always_comb
    begin
        run_total[SLOT_UP]    = p1_slot_reg[SLOT_UP] ?
                                risk_add(risk_reg, p1_cand_reg[SLOT_UP].h) : risk_reg;
        run_total[SLOT_LEFT]  = p1_slot_reg[SLOT_LEFT] ?
                                risk_add(run_total[SLOT_UP], p1_cand_reg[SLOT_LEFT].h) :
                                run_total[SLOT_UP];
        run_total[SLOT_FINAL] = p1_slot_reg[SLOT_FINAL] ?
                                risk_add(run_total[SLOT_LEFT], p1_cand_reg[SLOT_FINAL].h) :
                                run_total[SLOT_LEFT];
        run_total[SLOT_DONE]  = run_total[SLOT_FINAL];

        // Each found result takes the next free place after those found before it.
        slot_pos[0] = 2'd0;
        for (int k = 1; k < NUM_SLOTS; k++)
        begin
            slot_pos[k] = slot_pos[k-1] + 2'(p1_slot_reg[k-1]);
        end

        later_found = 1'b0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--)
        begin
            word[k].risk_total  = run_total[k];
            word[k].last_of_run = !later_found;
            if (k == SLOT_DONE)
            begin
                word[k].kind        = KIND_DONE;
                word[k].row         = '0;
                word[k].col         = '0;
                word[k].cell_height = '0;
            end
            else
            begin
                word[k].kind        = KIND_LOW;
                word[k].row         = p1_cand_reg[k].row;
                word[k].col         = p1_cand_reg[k].col;
                word[k].cell_height = p1_cand_reg[k].h;
            end
            later_found = later_found || p1_slot_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            risk_reg <= '0;
        end
        else if (cfg_restart)
        begin
            risk_reg <= '0;
        end
        else if (move)
        begin
            risk_reg <= p1_slot_reg[SLOT_DONE] ? '0 : run_total[SLOT_FINAL];
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to four words written per cycle, one read.
    // ------------------------------------------------------------------
    res_word_t        rq_mem [RQ_DEPTH];
    logic [RQ_PW-1:0] rq_wr_reg, rq_rd_reg;
    logic             pop;
    res_word_t        head;

    assign head = rq_mem[rq_rd_reg];
    assign pop  = results.valid && results.ready;

    assign results.valid       = (rq_count_reg != '0);
    assign results.kind        = head.kind;
    assign results.row         = head.row;
    assign results.col         = head.col;
    assign results.cell_height = head.cell_height;
    assign results.risk_total  = head.risk_total;
    assign results.last_of_run = head.last_of_run;

    always_comb
    begin
        rq_count_next = rq_count_reg;
        if (move)
        begin
            rq_count_next = rq_count_next + p1_count;
        end
        if (pop)
        begin
            rq_count_next = rq_count_next - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (move && p1_slot_reg[k])
            begin
                rq_mem[rq_wr_reg + RQ_PW'(slot_pos[k])] <= word[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_count_reg <= '0;
            rq_wr_reg    <= '0;
            rq_rd_reg    <= '0;
        end
        else
        begin
            rq_count_reg <= rq_count_next;
            if (move)
            begin
                rq_wr_reg <= rq_wr_reg + RQ_PW'(p1_count);
            end
            if (pop)
            begin
                rq_rd_reg <= rq_rd_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_count_reg <= RQ_CW'(RQ_DEPTH))
        else $error("result queue holds more words than its depth");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= w_last_reg)
        else $error("column counter ran past the last column");

    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        pop && results.kind == KIND_DONE |-> results.last_of_run)
        else $error("frame done word is not the last word of its pixel");

    a_total_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        move && p1_slot_reg[SLOT_DONE] |=> risk_reg == '0)
        else $error("running total not cleared after frame done");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> p1_valid_reg && (rq_count_reg != '0))
        else $error("pixel stalled while the result queue is empty");

endmodule
